@@ rtl/core/sqt_pkg.sv @@
// ----------------------------------------------------------------------------
// sqt_pkg
// Shared types, codes and default sizes of the time-then-id swap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sqt_pkg;

  // default sizes for the top level parameters
  localparam int unsigned DefQueueDepth = 64;
  localparam int unsigned DefIdCount    = 256;
  localparam int unsigned DefTimeBits   = 16;

  // widest entry time the command path carries
  localparam int unsigned MaxTimeBits   = 32;

  // result status codes
  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_REMOVED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // request codes
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // classified command from front to back
  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_EMPTY,
    OP_FULL
  } cmd_op_e;

  // input transaction
  typedef struct packed {
    logic        req_type;
    logic [7:0]  proc_id;
    logic [15:0] created_time;
    logic [15:0] now_time;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_id;
    logic [15:0] out_time;
  } res_t;

  // command handed to the back end
  typedef struct packed {
    cmd_op_e                op;
    logic [7:0]             id;
    logic [MaxTimeBits-1:0] etime;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/sqt_fifo.sv @@
// ----------------------------------------------------------------------------
// sqt_fifo
// Small register queue used between front and back and on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module sqt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] rdata_o,
  output      logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d;
  logic [PW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // pointer and count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sqt_front.sv @@
// ----------------------------------------------------------------------------
// sqt_front
// Accepts requests, looks up the seen bitmap, picks the entry time and
// classifies each request against a shadow fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module sqt_front
  import sqt_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth,
  parameter int unsigned ID_COUNT    = DefIdCount,
  parameter int unsigned TIME_BITS   = DefTimeBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire in_t  in_item_i,
  output      logic full_o,
  output      logic cmd_push_o,
  output      cmd_t cmd_o,
  input  wire logic cmd_full_i
);

  localparam int unsigned IW = $clog2(ID_COUNT);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic          seen_mem [ID_COUNT];
  logic          clr_q;
  logic [IW-1:0] clr_idx_q;
  logic          pend_q;
  in_t           item_q;
  logic          seen_rd_q;
  logic [CW-1:0] fcount_q, fcount_d;

  logic          accept;
  logic [31:0]   in_pid32, item_pid32;
  logic [IW-1:0] in_idx, item_idx;
  logic          item_in_range, known;
  logic [31:0]   time_sel32;
  logic [TIME_BITS-1:0] time_masked;
  logic          seen_we;
  logic [IW-1:0] seen_waddr;
  logic          seen_wdata;

  assign full_o = clr_q | pend_q;
  assign accept = push_i & ~full_o;

  // id lookup index and range check
  assign in_pid32      = 32'(in_item_i.proc_id);
  assign in_idx        = in_pid32[IW-1:0];
  assign item_pid32    = 32'(item_q.proc_id);
  assign item_idx      = item_pid32[IW-1:0];
  assign item_in_range = (item_pid32 < 32'(ID_COUNT));
  assign known         = item_in_range & seen_rd_q;

  // entry time, masked to the stored width
  assign time_sel32  = known ? 32'(item_q.now_time) : 32'(item_q.created_time);
  assign time_masked = time_sel32[TIME_BITS-1:0];

  // classify against the shadow fill count
  always_comb begin
    fcount_d    = fcount_q;
    cmd_o.id    = item_q.proc_id;
    cmd_o.etime = MaxTimeBits'(time_masked);
    cmd_o.op    = OP_ADD;
    if (item_q.req_type == REQ_ADD) begin
      if (fcount_q == CW'(QUEUE_DEPTH)) begin
        cmd_o.op = OP_FULL;
      end else begin
        cmd_o.op = OP_ADD;
        fcount_d = fcount_q + CW'(1);
      end
    end else begin
      if (fcount_q == '0) begin
        cmd_o.op = OP_EMPTY;
      end else begin
        cmd_o.op = OP_REMOVE;
        fcount_d = fcount_q - CW'(1);
      end
    end
  end

  assign cmd_push_o = pend_q & ~cmd_full_i;

  // seen bitmap write port: clearing pass, then first-visit marks
  always_comb begin
    seen_we    = 1'b0;
    seen_waddr = item_idx;
    seen_wdata = 1'b1;
    if (clr_q) begin
      seen_we    = 1'b1;
      seen_waddr = clr_idx_q;
      seen_wdata = 1'b0;
    end else if (cmd_push_o && cmd_o.op == OP_ADD && item_in_range) begin
      seen_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_mem[seen_waddr] <= seen_wdata;
    end
    if (accept) begin
      seen_rd_q <= seen_mem[in_idx];
    end
  end

  // held request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      pend_q    <= 1'b0;
      fcount_q  <= '0;
    end else begin
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + IW'(1);
        if (clr_idx_q == IW'(ID_COUNT - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (accept) begin
        pend_q <= 1'b1;
      end else if (cmd_push_o) begin
        pend_q   <= 1'b0;
        fcount_q <= fcount_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sqt_back.sv @@
// ----------------------------------------------------------------------------
// sqt_back
// Carries out classified commands on the slot memories: appends entries,
// scans the leading equal-time run for the lowest id and closes the gap.
// ----------------------------------------------------------------------------
`default_nettype none

module sqt_back
  import sqt_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth,
  parameter int unsigned TIME_BITS   = DefTimeBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire logic cmd_empty_i,
  output      logic cmd_pop_o,
  output      logic res_push_o,
  output      res_t res_o,
  input  wire logic res_full_i
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [7:0]           id_mem   [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] time_mem [QUEUE_DEPTH];

  logic [1:0]           state_q, state_d;
  logic [CW-1:0]        fill_q, fill_d;
  logic [AW-1:0]        sidx_q, sidx_d;
  logic [AW-1:0]        j_q, j_d;
  logic [TIME_BITS-1:0] head_q, head_d;
  logic [7:0]           best_id_q, best_id_d;
  logic [AW-1:0]        best_idx_q, best_idx_d;
  logic [7:0]           rid_q;
  logic [TIME_BITS-1:0] rtime_q;

  logic [AW-1:0]        raddr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [7:0]           wid;
  logic [TIME_BITS-1:0] wtime;
  logic [CW-1:0]        last_idx;
  logic                 run_end, scan_done, shift_last;
  logic [31:0]          head32;

  assign last_idx   = fill_q - CW'(1);
  assign cmd_pop_o  = (state_q == S_IDLE) & ~cmd_empty_i & ~res_full_i;
  assign head32     = 32'(head_q);
  assign shift_last = ((CW'(j_q) + CW'(1)) == last_idx);

  // running best over the leading equal-time run
  always_comb begin
    head_d     = head_q;
    best_id_d  = best_id_q;
    best_idx_d = best_idx_q;
    run_end    = 1'b0;
    if (state_q == S_SCAN) begin
      if (sidx_q == '0) begin
        head_d     = rtime_q;
        best_id_d  = rid_q;
        best_idx_d = '0;
      end else if (rtime_q != head_q) begin
        run_end = 1'b1;
      end else if (rid_q < best_id_q) begin
        best_id_d  = rid_q;
        best_idx_d = sidx_q;
      end
    end
  end

  assign scan_done = run_end | (CW'(sidx_q) == last_idx);

  // sequencer
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    sidx_d     = sidx_q;
    j_d        = j_q;
    raddr      = '0;
    we         = 1'b0;
    waddr      = j_q;
    wid        = rid_q;
    wtime      = rtime_q;
    res_push_o = 1'b0;
    res_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_pop_o) begin
          unique case (cmd_i.op)
            OP_ADD: begin
              we         = 1'b1;
              waddr      = fill_q[AW-1:0];
              wid        = cmd_i.id;
              wtime      = cmd_i.etime[TIME_BITS-1:0];
              fill_d     = fill_q + CW'(1);
              res_push_o = 1'b1;
              res_o.status = ST_ADDED;
            end
            OP_FULL: begin
              res_push_o   = 1'b1;
              res_o.status = ST_FULL;
            end
            OP_EMPTY: begin
              res_push_o   = 1'b1;
              res_o.status = ST_EMPTY;
            end
            OP_REMOVE: begin
              sidx_d  = '0;
              state_d = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          raddr = best_idx_d + AW'(1);
          j_d   = best_idx_d;
          if (CW'(best_idx_d) == last_idx) begin
            state_d = S_FIN;
          end else begin
            state_d = S_SHIFT;
          end
        end else begin
          raddr  = sidx_q + AW'(1);
          sidx_d = sidx_q + AW'(1);
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        raddr = j_q + AW'(1) + AW'(1);
        j_d   = j_q + AW'(1);
        if (shift_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        fill_d         = fill_q - CW'(1);
        res_push_o     = 1'b1;
        res_o.status   = ST_REMOVED;
        res_o.out_id   = best_id_q;
        res_o.out_time = head32[15:0];
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // slot memories, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      id_mem[waddr]   <= wid;
      time_mem[waddr] <= wtime;
    end
    rid_q   <= id_mem[raddr];
    rtime_q <= time_mem[raddr];
  end

  // scan payload
  always_ff @(posedge clk_i) begin
    head_q     <= head_d;
    best_id_q  <= best_id_d;
    best_idx_q <= best_idx_d;
    sidx_q     <= sidx_d;
    j_q        <= j_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  // a result is only produced when space was reserved at command pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  // a scan only runs over a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (fill_q != '0) && (CW'(sidx_q) < fill_q))
    else $error("scan index outside the filled slots");

  // shifting only moves slots below the last valid one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> ((CW'(j_q) + CW'(1)) < fill_q))
    else $error("shift beyond the filled slots");

  // an add never overruns the slot store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_i.op == OP_ADD) |-> (fill_q < CW'(QUEUE_DEPTH)))
    else $error("add into a full slot store");

  // a remove always finishes with a removed result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> ($past(res_push_o) && (state_q == S_IDLE)))
    else $error("remove did not complete");

endmodule

`default_nettype wire

@@ rtl/core/swap_queue_time_then_id.sv @@
// ----------------------------------------------------------------------------
// swap_queue_time_then_id
// Ordered swap queue of process entries picked by head time, then lowest id.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-------------------------
//  request   | in        | push_i / full_o        | in_item_i  (in_t)
//  result    | out       | empty_o / pop_i        | out_item_o (res_t)
//
//  an add writes its slot and pushes its result when the back takes the
//  command; a remove first scans the leading equal-time run and then shifts
//  any later entries down over the single read and write port of the slot
//  memories before its result is pushed
//  after reset the seen bitmap is cleared with full_o high
//  the front holds one request and a two-entry command queue decouples it
//  from the back; a two-entry result queue lets requests enter while results
//  wait to be popped
// ----------------------------------------------------------------------------
`default_nettype none

module swap_queue_time_then_id
  import sqt_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth,
  parameter int unsigned ID_COUNT    = DefIdCount,
  parameter int unsigned TIME_BITS   = DefTimeBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire in_t  in_item_i,
  output      logic full_o,
  output      logic empty_o,
  input  wire logic pop_i,
  output      res_t out_item_o
);

  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned ResW = $bits(res_t);

  cmd_t            cmd_push_data, cmd_pop_data;
  logic [CmdW-1:0] cmd_rd_vec;
  logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
  res_t            res_push_data;
  logic [ResW-1:0] res_rd_vec;
  logic            res_push, res_full;

  // request side: lookup and classification
  sqt_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_COUNT    (ID_COUNT),
    .TIME_BITS   (TIME_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .in_item_i  (in_item_i),
    .full_o     (full_o),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_push_data),
    .cmd_full_i (cmd_full)
  );

  // command queue between front and back
  sqt_fifo #(
    .WIDTH (CmdW),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_push_data),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rd_vec),
    .empty_o (cmd_empty)
  );

  assign cmd_pop_data = cmd_t'(cmd_rd_vec);

  // slot store and remove sequencer
  sqt_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_pop_data),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_push_data),
    .res_full_i  (res_full)
  );

  // result queue
  sqt_fifo #(
    .WIDTH (ResW),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_push_data),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (res_rd_vec),
    .empty_o (empty_o)
  );

  assign out_item_o = res_t'(res_rd_vec);

endmodule

`default_nettype wire
